// ----- rtl/vsg_pkg.sv -----
// ----------------------------------------------------------------------------
// vsg_pkg
// Shared constants and types for the VGA scanline generator: framebuffer
// geometry, register indexes, register reset values and the RAM write beat.
// ----------------------------------------------------------------------------
package vsg_pkg;

  // Framebuffer geometry: rows of words, eight 4-bit pixels per word.
  localparam int unsigned FB_ROWS  = 240;
  localparam int unsigned FB_WORDS = 40;
  localparam int unsigned FB_DEPTH = FB_ROWS * FB_WORDS;
  localparam int unsigned FB_AW    = $clog2(FB_DEPTH);

  // Largest number of words sent on one line.
  localparam int unsigned MAX_OUT  = 40;

  // Field widths.
  localparam int unsigned ROW_W    = 8;
  localparam int unsigned WIDX_W   = 6;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned LINE_W   = 10;
  localparam int unsigned CFG_IW   = 3;
  localparam int unsigned CFG_DW   = 10;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] REG_ENABLED     = 3'd0;
  localparam logic [CFG_IW-1:0] REG_WORDS_LINE  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_FRAME_LINES = 3'd2;
  localparam logic [CFG_IW-1:0] REG_VS_START    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_VS_END      = 3'd4;

  // Register reset values.
  localparam logic [WIDX_W-1:0] RST_WORDS_LINE  = 6'd40;
  localparam logic [LINE_W-1:0] RST_FRAME_LINES = 10'd525;
  localparam logic [LINE_W-1:0] RST_VS_START    = 10'd490;
  localparam logic [LINE_W-1:0] RST_VS_END      = 10'd492;

  // Input kind carried on the slave-side tuser.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // One write into the framebuffer RAM.
  typedef struct packed {
    logic              en;
    logic [FB_AW-1:0]  addr;
    logic [WORD_W-1:0] data;
  } fb_wr_t;

endpackage

// ----- rtl/vga_scanline_generator.sv -----
// ----------------------------------------------------------------------------
// vga_scanline_generator
// Line-doubled scanline generator over a 4-bit-pixel framebuffer.
// ----------------------------------------------------------------------------
// A scanline tick streams min(words_per_line, 40) framebuffer words, one beat
// per cycle while the result side keeps up, or one blank beat when output is
// paused, the row is off the framebuffer or the word count is zero; the block
// takes the next input beat in the cycle after the tick's last word read is
// issued, so a tick holds off the input while its reads are issued, which
// takes longer while the result side stalls. The rate is set by the single
// read port of the framebuffer RAM, which delivers one word per cycle with
// registered read data. A two-entry output queue holds results while the
// result side stalls, and reads are issued only while the queue leaves room;
// the line counter, vsync level and row prefetch are updated in the cycle
// that the tick is taken, so results carry the values of their own line.
// Each framebuffer row is shown on two consecutive lines.
module vga_scanline_generator (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_wdata,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // row[7:0], word_index[13:8], word_data[45:14]
  input  logic        in_tuser,   // func[0]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // pixel_word[31:0], vsync_level[32], scan_line[42:33]
  output logic        out_tuser,  // has_pixels[0]
  output logic        out_tlast
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_STREAM = 1'b1;

  typedef struct packed {
    logic [vsg_pkg::WORD_W-1:0] word;
    logic                       has;
    logic                       vs;
    logic [vsg_pkg::LINE_W-1:0] line;
    logic                       last;
  } beat_t;

  // Configuration registers.
  logic                        enabled_r;
  logic [vsg_pkg::WIDX_W-1:0]  words_line_r;
  logic [vsg_pkg::LINE_W-1:0]  frame_lines_r;
  logic [vsg_pkg::LINE_W-1:0]  vs_start_r;
  logic [vsg_pkg::LINE_W-1:0]  vs_end_r;

  // Timing state.
  logic [vsg_pkg::LINE_W-1:0]  line_count_r, line_count_nxt;
  logic [vsg_pkg::ROW_W-1:0]   next_row_r, next_row_nxt;
  logic                        dphase_r, dphase_nxt;
  logic [vsg_pkg::ROW_W-1:0]   fetched_row_r, fetched_row_nxt;
  logic                        fetched_valid_r, fetched_valid_nxt;
  logic                        vsync_r, vsync_nxt;

  // Streaming control.
  logic                        state_r, state_nxt;
  logic [vsg_pkg::FB_AW-1:0]   addr_r, addr_nxt;
  logic [vsg_pkg::WIDX_W-1:0]  remain_r, remain_nxt;
  logic                        has_r, has_nxt;
  logic                        svs_r, svs_nxt;
  logic [vsg_pkg::LINE_W-1:0]  sline_r, sline_nxt;

  // Read in flight and its beat attributes.
  logic                        pend_r;
  beat_t                       pend_meta_r;

  // Output queue.
  beat_t                       q0_r, q1_r;
  logic [1:0]                  qcnt_r;

  // Input fields.
  logic [vsg_pkg::ROW_W-1:0]   in_row;
  logic [vsg_pkg::WIDX_W-1:0]  in_widx;
  logic [vsg_pkg::WORD_W-1:0]  in_word;
  logic                        in_acc;
  logic                        tick_acc;
  logic                        wr_acc;

  logic [vsg_pkg::WIDX_W-1:0]  word_cnt;
  logic                        stream_ok;
  logic [vsg_pkg::LINE_W-1:0]  line_inc;

  logic                        pop;
  logic                        issue;
  logic [1:0]                  occ;
  beat_t                       push_beat;

  vsg_pkg::fb_wr_t             fb_wr;
  logic [vsg_pkg::WORD_W-1:0]  fb_rdata;

  assign in_row  = in_tdata[7:0];
  assign in_widx = in_tdata[13:8];
  assign in_word = in_tdata[45:14];

  // No input beat is taken while reset is held.
  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign tick_acc  = in_acc && (in_tuser == vsg_pkg::FUNC_TICK);
  assign wr_acc    = in_acc && (in_tuser == vsg_pkg::FUNC_WRITE);

  // Framebuffer write, out-of-range positions dropped.
  always_comb begin
    fb_wr.en   = wr_acc
                 && (in_row < vsg_pkg::ROW_W'(vsg_pkg::FB_ROWS))
                 && (in_widx < vsg_pkg::WIDX_W'(vsg_pkg::FB_WORDS));
    fb_wr.addr = vsg_pkg::FB_AW'(in_row) * vsg_pkg::FB_AW'(vsg_pkg::FB_WORDS)
                 + vsg_pkg::FB_AW'(in_widx);
    fb_wr.data = in_word;
  end

  vsg_fb_ram u_fb_ram (
    .clk     (clk),
    .wr      (fb_wr),
    .rd_en   (issue && has_r),
    .rd_addr (addr_r),
    .rd_data (fb_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r     <= 1'b1;
      words_line_r  <= vsg_pkg::RST_WORDS_LINE;
      frame_lines_r <= vsg_pkg::RST_FRAME_LINES;
      vs_start_r    <= vsg_pkg::RST_VS_START;
      vs_end_r      <= vsg_pkg::RST_VS_END;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vsg_pkg::REG_ENABLED:     enabled_r     <= cfg_wdata[0];
        vsg_pkg::REG_WORDS_LINE:  words_line_r  <= cfg_wdata[vsg_pkg::WIDX_W-1:0];
        vsg_pkg::REG_FRAME_LINES: frame_lines_r <= cfg_wdata;
        vsg_pkg::REG_VS_START:    vs_start_r    <= cfg_wdata;
        vsg_pkg::REG_VS_END:      vs_end_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Words on this line and whether the line carries pixels.
  always_comb begin
    word_cnt  = (words_line_r > vsg_pkg::WIDX_W'(vsg_pkg::MAX_OUT))
                ? vsg_pkg::WIDX_W'(vsg_pkg::MAX_OUT) : words_line_r;
    if (word_cnt > vsg_pkg::WIDX_W'(vsg_pkg::FB_WORDS)) begin
      word_cnt = vsg_pkg::WIDX_W'(vsg_pkg::FB_WORDS);
    end
    stream_ok = enabled_r && fetched_valid_r
                && (fetched_row_r < vsg_pkg::ROW_W'(vsg_pkg::FB_ROWS))
                && (word_cnt != '0);
  end

  // Line counter, vsync and row prefetch advance when a tick is taken.
  always_comb begin
    line_inc          = line_count_r + 1'b1;
    line_count_nxt    = line_count_r;
    next_row_nxt      = next_row_r;
    dphase_nxt        = dphase_r;
    fetched_row_nxt   = fetched_row_r;
    fetched_valid_nxt = fetched_valid_r;
    vsync_nxt         = vsync_r;
    if (tick_acc) begin
      line_count_nxt = line_inc;
      if (line_inc == frame_lines_r) begin
        line_count_nxt = '0;
        next_row_nxt   = '0;
        dphase_nxt     = 1'b0;
      end else if (line_inc == vs_start_r) begin
        vsync_nxt = 1'b0;
      end else if (line_inc == vs_end_r) begin
        vsync_nxt = 1'b1;
      end
      fetched_row_nxt   = next_row_nxt;
      fetched_valid_nxt = (next_row_nxt < vsg_pkg::ROW_W'(vsg_pkg::FB_ROWS));
      if (dphase_nxt && (next_row_nxt != '1)) begin
        next_row_nxt = next_row_nxt + 1'b1;
      end
      dphase_nxt = !dphase_nxt;
    end
  end

  // Read issue: only while the queue plus the read in flight leave room.
  assign pop   = out_tvalid && out_tready;
  assign occ   = qcnt_r + {1'b0, pend_r};
  assign issue = (state_r == ST_STREAM) && ((occ < 2'd2) || pop);

  // Stream sequencer.
  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    remain_nxt = remain_r;
    has_nxt    = has_r;
    svs_nxt    = svs_r;
    sline_nxt  = sline_r;
    unique case (state_r)
      ST_IDLE: begin
        if (tick_acc) begin
          state_nxt  = ST_STREAM;
          addr_nxt   = vsg_pkg::FB_AW'(fetched_row_r)
                       * vsg_pkg::FB_AW'(vsg_pkg::FB_WORDS);
          has_nxt    = stream_ok;
          remain_nxt = stream_ok ? word_cnt : vsg_pkg::WIDX_W'(1);
          svs_nxt    = vsync_r;
          sline_nxt  = line_count_r;
        end
      end
      ST_STREAM: begin
        if (issue) begin
          addr_nxt   = addr_r + 1'b1;
          remain_nxt = remain_r - 1'b1;
          if (remain_r == vsg_pkg::WIDX_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      line_count_r    <= '0;
      next_row_r      <= '0;
      dphase_r        <= 1'b0;
      fetched_row_r   <= '0;
      fetched_valid_r <= 1'b1;
      vsync_r         <= 1'b1;
      pend_r          <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      line_count_r    <= line_count_nxt;
      next_row_r      <= next_row_nxt;
      dphase_r        <= dphase_nxt;
      fetched_row_r   <= fetched_row_nxt;
      fetched_valid_r <= fetched_valid_nxt;
      vsync_r         <= vsync_nxt;
      pend_r          <= issue;
    end
  end

  // Per-tick payload registers and attributes of the read in flight.
  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    remain_r <= remain_nxt;
    has_r    <= has_nxt;
    svs_r    <= svs_nxt;
    sline_r  <= sline_nxt;
    if (issue) begin
      pend_meta_r.word <= '0;
      pend_meta_r.has  <= has_r;
      pend_meta_r.vs   <= svs_r;
      pend_meta_r.line <= sline_r;
      pend_meta_r.last <= (remain_r == vsg_pkg::WIDX_W'(1));
    end
  end

  // Beat entering the queue: RAM data for pixel beats, zero for a blank line.
  always_comb begin
    push_beat      = pend_meta_r;
    push_beat.word = pend_meta_r.has ? fb_rdata : '0;
  end

  // Two-entry output queue, head in q0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r <= '0;
    end else begin
      unique case ({pend_r, pop})
        2'b01:   qcnt_r <= qcnt_r - 1'b1;
        2'b10:   qcnt_r <= qcnt_r + 1'b1;
        default: qcnt_r <= qcnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({pend_r, pop})
      2'b01: begin
        q0_r <= q1_r;
      end
      2'b10: begin
        if (qcnt_r == 2'd0) begin
          q0_r <= push_beat;
        end else begin
          q1_r <= push_beat;
        end
      end
      2'b11: begin
        if (qcnt_r == 2'd1) begin
          q0_r <= push_beat;
        end else begin
          q0_r <= q1_r;
          q1_r <= push_beat;
        end
      end
      default: ;
    endcase
  end

  // Result port.
  assign out_tvalid = (qcnt_r != 2'd0);
  assign out_tdata  = {5'd0, q0_r.line, q0_r.vs, q0_r.word};
  assign out_tuser  = q0_r.has;
  assign out_tlast  = q0_r.last;

endmodule

// ----- rtl/vsg_fb_ram.sv -----
// ----------------------------------------------------------------------------
// vsg_fb_ram
// Framebuffer storage: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module vsg_fb_ram (
  input  logic                           clk,
  input  vsg_pkg::fb_wr_t                wr,
  input  logic                           rd_en,
  input  logic [vsg_pkg::FB_AW-1:0]      rd_addr,
  output logic [vsg_pkg::WORD_W-1:0]     rd_data
);

  logic [vsg_pkg::WORD_W-1:0] mem [0:vsg_pkg::FB_DEPTH-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/vsg_checker.sv -----
// ----------------------------------------------------------------------------
// vsg_checker
// Port-level checks for the VGA scanline generator, bound to the top level.
// ----------------------------------------------------------------------------
module vsg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // No result beat right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result beat shown right after reset");

  // A blank-line beat is a single zero beat that closes its line.
  a_blank_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tlast && (out_tdata[31:0] == 32'd0)))
    else $error("blank beat is not a single zero beat");

  // Beats of one line carry the same line number and vsync level.
  a_line_same: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (!out_tvalid || ((out_tdata[42:32] == $past(out_tdata[42:32]))
                       && out_tuser))
    ) else $error("line attributes change inside a line");

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result beat dropped or changed");

endmodule

bind vga_scanline_generator vsg_checker u_vsg_checker (.*);
